// ----- rtl/mgmt_pkg.sv -----
`timescale 1ns / 1ps
package mgmt_pkg;

   localparam int GROUP_ENTRIES   = 256;
   localparam int SLOTS_PER_GROUP = 64;
   localparam int GW              = $clog2(GROUP_ENTRIES);
   localparam int SW              = $clog2(SLOTS_PER_GROUP);
   localparam int AW              = $clog2(GROUP_ENTRIES * SLOTS_PER_GROUP);
   localparam int CW              = 7;
   localparam int IFW             = 32;
   localparam int KW              = 32;

   localparam logic OP_JOIN  = 1'b0;
   localparam logic OP_LEAVE = 1'b1;

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_READY     = 1'b1;

   localparam logic [CW-1:0] THRESHOLD_RESET = 7'd8;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_TABLE_FULL = 3'd1,
      STAT_SLOTS_FULL = 3'd2,
      STAT_NO_GROUP   = 3'd3,
      STAT_NO_SUB     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SM_FREE,
      SM_MATCH,
      SM_USED
   } scan_mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GSCAN,
      S_GFETCH,
      S_GLOAD,
      S_SSCAN,
      S_COMMIT,
      S_CHECK,
      S_OSCAN,
      S_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic          load;
      logic          gscan;
      logic          alloc;
      logic          miss;
      logic          gload;
      logic          sclr;
      logic          sscan;
      scan_mode_type smode;
      logic          commit;
      logic          fail;
      logic          emit;
   } dp_cmd_type;

   typedef struct packed {
      logic op_leave;
      logic ghit;
      logic gfree;
      logic gdone;
      logic sfound;
      logic sdone;
      logic cnt_one;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/mgmt_ram.sv -----
`timescale 1ns / 1ps
module mgmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mgmt_ctrl.sv -----
`timescale 1ns / 1ps
module mgmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mgmt_pkg::dp_status_type st,
   output mgmt_pkg::dp_cmd_type    cmd
);

   mgmt_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mgmt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.smode = mgmt_pkg::SM_FREE;
      req_ready = 1'b0;
      case (state_ff)
         mgmt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mgmt_pkg::S_GSCAN;
            end
         end
         mgmt_pkg::S_GSCAN: begin
            cmd.gscan = 1'b1;
            if (st.ghit) begin
               state_in = mgmt_pkg::S_GFETCH;
            end else if (st.gdone) begin
               if (!st.op_leave && st.gfree) begin
                  cmd.alloc = 1'b1;
                  cmd.sclr  = 1'b1;
                  state_in  = mgmt_pkg::S_SSCAN;
               end else begin
                  cmd.miss = 1'b1;
                  state_in = mgmt_pkg::S_RESULT;
               end
            end
         end
         mgmt_pkg::S_GFETCH: begin
            state_in = mgmt_pkg::S_GLOAD;
         end
         mgmt_pkg::S_GLOAD: begin
            cmd.gload = 1'b1;
            cmd.sclr  = 1'b1;
            state_in  = mgmt_pkg::S_SSCAN;
         end
         mgmt_pkg::S_SSCAN: begin
            cmd.sscan = 1'b1;
            cmd.smode = st.op_leave ? mgmt_pkg::SM_MATCH : mgmt_pkg::SM_FREE;
            if (st.sfound) begin
               state_in = mgmt_pkg::S_COMMIT;
            end else if (st.sdone) begin
               cmd.fail = 1'b1;
               cmd.sclr = 1'b1;
               state_in = mgmt_pkg::S_CHECK;
            end
         end
         mgmt_pkg::S_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.sclr   = 1'b1;
            state_in   = mgmt_pkg::S_CHECK;
         end
         mgmt_pkg::S_CHECK: begin
            // a lone subscriber must be looked up for the result
            state_in = st.cnt_one ? mgmt_pkg::S_OSCAN : mgmt_pkg::S_RESULT;
         end
         mgmt_pkg::S_OSCAN: begin
            cmd.sscan = 1'b1;
            cmd.smode = mgmt_pkg::SM_USED;
            if (st.sfound || st.sdone) begin
               state_in = mgmt_pkg::S_RESULT;
            end
         end
         mgmt_pkg::S_RESULT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = mgmt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mgmt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/mgmt_dp.sv -----
`timescale 1ns / 1ps
module mgmt_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  mgmt_pkg::dp_cmd_type           cmd,
   output mgmt_pkg::dp_status_type        st,
   input  logic [mgmt_pkg::CW-1:0]        cfg_threshold,
   input  logic                          cfg_ready,
   input  logic                          req_operation,
   input  logic [31:0]                   req_group_address,
   input  logic [31:0]                   req_interface_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [7:0]                    rsp_entry_index,
   output logic [5:0]                    rsp_subscriber_slot,
   output logic [6:0]                    rsp_subscriber_count,
   output logic [31:0]                   rsp_single_subscriber,
   output logic                          rsp_fast_path_on,
   output logic                          rsp_upstream_join,
   output logic                          rsp_upstream_leave
);

   localparam int N  = mgmt_pkg::GROUP_ENTRIES;
   localparam int S  = mgmt_pkg::SLOTS_PER_GROUP;
   localparam int GW = mgmt_pkg::GW;
   localparam int SW = mgmt_pkg::SW;
   localparam int AW = mgmt_pkg::AW;
   localparam int CW = mgmt_pkg::CW;

   // request
   logic                       op_ff;
   logic [mgmt_pkg::KW-1:0]    addr_ff;
   logic [mgmt_pkg::IFW-1:0]   ifx_ff;

   // group table
   logic [N-1:0]               valid_ff;
   logic [GW:0]                gcnt_ff;
   logic                       chk_vld_ff;
   logic [GW-1:0]              chk_idx_ff;
   logic                       hit_ff, free_found_ff, gdone_ff;
   logic [GW-1:0]              free_ff, g_ff;

   // working copy of the group
   logic [S-1:0]               row_ff;
   logic [CW-1:0]              cnt_ff;
   logic                       fast_ff, fresh_ff, uleave_ff;
   mgmt_pkg::status_type       stat_ff;
   logic [SW-1:0]              s_ff;
   logic [mgmt_pkg::IFW-1:0]   sole_ff;

   // slot scan
   logic [SW:0]                sidx_ff;
   logic                       schk_vld_ff;
   logic [SW-1:0]              schk_idx_ff;
   logic                       sfound_ff, sdone_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_status_ff;
   logic [7:0]                 rsp_entry_ff;
   logic [5:0]                 rsp_slot_ff;
   logic [6:0]                 rsp_count_ff;
   logic [31:0]                rsp_sole_ff;
   logic                       rsp_fast_ff, rsp_ujoin_ff, rsp_uleave_ff;

   // memories
   logic [mgmt_pkg::KW-1:0]    key_rdata;
   logic [S-1:0]               row_rdata;
   logic [CW:0]                cnt_rdata;
   logic [mgmt_pkg::IFW-1:0]   ifx_rdata;
   logic [AW-1:0]              ifx_raddr, ifx_waddr;

   logic                       g_issue, s_issue, s_cond, g_key_hit;
   logic [S-1:0]               row_new;
   logic [CW-1:0]              cnt_new;
   logic                       fast_new;

   assign g_issue   = cmd.gscan && (gcnt_ff < (GW+1)'(N));
   assign s_issue   = cmd.sscan && (sidx_ff < (SW+1)'(S));
   assign g_key_hit = valid_ff[chk_idx_ff] && (key_rdata == addr_ff);

   assign ifx_raddr = AW'(g_ff) * AW'(S) + AW'(sidx_ff[SW-1:0]);
   assign ifx_waddr = AW'(g_ff) * AW'(S) + AW'(s_ff);

   always_comb begin
      case (cmd.smode)
         mgmt_pkg::SM_FREE:  s_cond = !row_ff[schk_idx_ff];
         mgmt_pkg::SM_MATCH: s_cond = row_ff[schk_idx_ff] && (ifx_rdata == ifx_ff);
         mgmt_pkg::SM_USED:  s_cond = row_ff[schk_idx_ff];
         default:            s_cond = 1'b0;
      endcase
   end

   always_comb begin
      row_new  = row_ff;
      cnt_new  = cnt_ff;
      fast_new = fast_ff;
      if (op_ff == mgmt_pkg::OP_JOIN) begin
         row_new[s_ff] = 1'b1;
         cnt_new       = cnt_ff + CW'(1);
         if (cnt_new > cfg_threshold && cfg_ready) begin
            fast_new = 1'b1;
         end
      end else begin
         row_new[s_ff] = 1'b0;
         cnt_new       = (cnt_ff != '0) ? cnt_ff - CW'(1) : cnt_ff;
         if (cnt_new <= CW'(1)) begin
            fast_new = 1'b0;
         end
      end
   end

   mgmt_ram #(.WIDTH(mgmt_pkg::KW), .DEPTH(N)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc),
      .wr_addr (free_ff),
      .wr_data (addr_ff),
      .rd_addr (gcnt_ff[GW-1:0]),
      .rd_data (key_rdata)
   );

   mgmt_ram #(.WIDTH(S), .DEPTH(N)) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (g_ff),
      .wr_data (row_new),
      .rd_addr (g_ff),
      .rd_data (row_rdata)
   );

   mgmt_ram #(.WIDTH(CW+1), .DEPTH(N)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (g_ff),
      .wr_data ({fast_new, cnt_new}),
      .rd_addr (g_ff),
      .rd_data (cnt_rdata)
   );

   mgmt_ram #(.WIDTH(mgmt_pkg::IFW), .DEPTH(N * S)) u_ifx_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && (op_ff == mgmt_pkg::OP_JOIN)),
      .wr_addr (ifx_waddr),
      .wr_data (ifx_ff),
      .rd_addr (ifx_raddr),
      .rd_data (ifx_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         gdone_ff      <= 1'b0;
         schk_vld_ff   <= 1'b0;
         sfound_ff     <= 1'b0;
         sdone_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            chk_vld_ff    <= 1'b0;
            hit_ff        <= 1'b0;
            free_found_ff <= 1'b0;
            gdone_ff      <= 1'b0;
         end else if (cmd.gscan) begin
            chk_vld_ff <= g_issue;
            if (chk_vld_ff && !hit_ff) begin
               if (g_key_hit) begin
                  hit_ff <= 1'b1;
               end
               if (!valid_ff[chk_idx_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
               if (chk_idx_ff == GW'(N - 1)) begin
                  gdone_ff <= 1'b1;
               end
            end
         end

         if (cmd.alloc) begin
            valid_ff[free_ff] <= 1'b1;
         end else if (cmd.commit && op_ff == mgmt_pkg::OP_LEAVE && cnt_new == '0) begin
            // release the group on its last leave
            valid_ff[g_ff] <= 1'b0;
         end

         if (cmd.sclr) begin
            schk_vld_ff <= 1'b0;
            sfound_ff   <= 1'b0;
            sdone_ff    <= 1'b0;
         end else if (cmd.sscan) begin
            schk_vld_ff <= s_issue;
            if (schk_vld_ff && !sfound_ff) begin
               if (s_cond) begin
                  sfound_ff <= 1'b1;
               end else if (schk_idx_ff == SW'(S - 1)) begin
                  sdone_ff <= 1'b1;
               end
            end
         end

         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         addr_ff   <= req_group_address;
         ifx_ff    <= req_interface_index;
         gcnt_ff   <= '0;
         sole_ff   <= '0;
         s_ff      <= '0;
         fresh_ff  <= 1'b0;
         uleave_ff <= 1'b0;
      end
      if (cmd.gscan) begin
         if (g_issue) begin
            gcnt_ff <= gcnt_ff + (GW+1)'(1);
         end
         chk_idx_ff <= gcnt_ff[GW-1:0];
         if (chk_vld_ff && !hit_ff) begin
            if (g_key_hit) begin
               g_ff <= chk_idx_ff;
            end
            if (!valid_ff[chk_idx_ff] && !free_found_ff) begin
               free_ff <= chk_idx_ff;
            end
         end
      end
      if (cmd.alloc) begin
         g_ff     <= free_ff;
         row_ff   <= '0;
         cnt_ff   <= '0;
         fast_ff  <= 1'b0;
         fresh_ff <= 1'b1;
      end
      if (cmd.miss) begin
         g_ff    <= '0;
         cnt_ff  <= '0;
         fast_ff <= 1'b0;
         stat_ff <= (op_ff == mgmt_pkg::OP_LEAVE) ? mgmt_pkg::STAT_NO_GROUP
                                                  : mgmt_pkg::STAT_TABLE_FULL;
      end
      if (cmd.gload) begin
         row_ff  <= row_rdata;
         cnt_ff  <= cnt_rdata[CW-1:0];
         fast_ff <= cnt_rdata[CW];
      end
      if (cmd.sclr) begin
         sidx_ff <= '0;
      end else if (cmd.sscan) begin
         if (s_issue) begin
            sidx_ff <= sidx_ff + (SW+1)'(1);
         end
         schk_idx_ff <= sidx_ff[SW-1:0];
         if (schk_vld_ff && !sfound_ff && s_cond) begin
            if (cmd.smode == mgmt_pkg::SM_USED) begin
               sole_ff <= ifx_rdata;
            end else begin
               s_ff <= schk_idx_ff;
            end
         end
      end
      if (cmd.fail) begin
         s_ff    <= '0;
         stat_ff <= (op_ff == mgmt_pkg::OP_LEAVE) ? mgmt_pkg::STAT_NO_SUB
                                                  : mgmt_pkg::STAT_SLOTS_FULL;
      end
      if (cmd.commit) begin
         row_ff    <= row_new;
         cnt_ff    <= cnt_new;
         fast_ff   <= fast_new;
         stat_ff   <= mgmt_pkg::STAT_OK;
         uleave_ff <= (op_ff == mgmt_pkg::OP_LEAVE) && (cnt_new == '0);
      end
      if (cmd.emit) begin
         rsp_status_ff <= stat_ff;
         rsp_entry_ff  <= 8'(g_ff);
         rsp_slot_ff   <= 6'(s_ff);
         rsp_count_ff  <= cnt_ff;
         rsp_sole_ff   <= sole_ff;
         rsp_fast_ff   <= fast_ff;
         rsp_ujoin_ff  <= fresh_ff;
         rsp_uleave_ff <= uleave_ff;
      end
   end

   assign st.op_leave = (op_ff == mgmt_pkg::OP_LEAVE);
   assign st.ghit     = hit_ff;
   assign st.gfree    = free_found_ff;
   assign st.gdone    = gdone_ff;
   assign st.sfound   = sfound_ff;
   assign st.sdone    = sdone_ff;
   assign st.cnt_one  = (cnt_ff == CW'(1));
   assign st.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_entry_index       = rsp_entry_ff;
   assign rsp_subscriber_slot   = rsp_slot_ff;
   assign rsp_subscriber_count  = rsp_count_ff;
   assign rsp_single_subscriber = rsp_sole_ff;
   assign rsp_fast_path_on      = rsp_fast_ff;
   assign rsp_upstream_join     = rsp_ujoin_ff;
   assign rsp_upstream_leave    = rsp_uleave_ff;

endmodule

// ----- rtl/multicast_group_membership_table_top.sv -----
`timescale 1ns / 1ps
// Group membership table for snooped join/leave requests. One request is
// worked at a time and yields exactly one result. A request goes through the
// group search (up to GROUP_ENTRIES entries, one key RAM read per entry,
// ending early on a match) and the slot search (up to SLOTS_PER_GROUP
// slots, one slot per cycle), plus another slot pass of the same length
// when the group is left with a single subscriber. A finished result sits
// in an output register, so the next request is taken while it waits.
// No clearing pass is needed after reset.
module multicast_group_membership_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_group_address,
   input  logic [31:0] req_interface_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_entry_index,
   output logic [5:0]  rsp_subscriber_slot,
   output logic [6:0]  rsp_subscriber_count,
   output logic [31:0] rsp_single_subscriber,
   output logic        rsp_fast_path_on,
   output logic        rsp_upstream_join,
   output logic        rsp_upstream_leave,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [mgmt_pkg::CW-1:0] threshold_ff;
   logic                    ready_ff;
   mgmt_pkg::dp_cmd_type    cmd;
   mgmt_pkg::dp_status_type st;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mgmt_pkg::THRESHOLD_RESET;
         ready_ff     <= 1'b0;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            mgmt_pkg::REG_THRESHOLD: threshold_ff <= pwdata[mgmt_pkg::CW-1:0];
            mgmt_pkg::REG_READY:     ready_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         mgmt_pkg::REG_THRESHOLD: prdata = 32'(threshold_ff);
         mgmt_pkg::REG_READY:     prdata = 32'(ready_ff);
         default:                 prdata = '0;
      endcase
   end

   mgmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   mgmt_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .st                    (st),
      .cfg_threshold         (threshold_ff),
      .cfg_ready             (ready_ff),
      .req_operation         (req_operation),
      .req_group_address     (req_group_address),
      .req_interface_index   (req_interface_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_entry_index       (rsp_entry_index),
      .rsp_subscriber_slot   (rsp_subscriber_slot),
      .rsp_subscriber_count  (rsp_subscriber_count),
      .rsp_single_subscriber (rsp_single_subscriber),
      .rsp_fast_path_on      (rsp_fast_path_on),
      .rsp_upstream_join     (rsp_upstream_join),
      .rsp_upstream_leave    (rsp_upstream_leave)
   );

endmodule

// ----- rtl/mgmt_checker.sv -----
`timescale 1ns / 1ps
module mgmt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_entry_index,
   input logic [6:0]  rsp_subscriber_count,
   input logic [31:0] rsp_single_subscriber,
   input logic        rsp_fast_path_on,
   input logic        rsp_upstream_join,
   input logic        rsp_upstream_leave
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_subscriber_count))
      else $error("result changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mgmt_pkg::STAT_TABLE_FULL
                    || rsp_status == mgmt_pkg::STAT_NO_GROUP)
      |-> rsp_entry_index == '0 && rsp_subscriber_count == '0 && !rsp_upstream_join)
      else $error("missing group result not cleared");

   a_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_upstream_leave
      |-> rsp_subscriber_count == '0 && !rsp_fast_path_on
          && rsp_status == mgmt_pkg::STAT_OK)
      else $error("release with members or fast path");

   a_sole: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_subscriber_count != 7'd1 |-> rsp_single_subscriber == '0)
      else $error("sole subscriber shown with count not one");

   a_new_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_upstream_join
      |-> rsp_subscriber_count == 7'd1 && rsp_status == mgmt_pkg::STAT_OK)
      else $error("new group result inconsistent");

endmodule

bind multicast_group_membership_table_top mgmt_checker u_mgmt_checker (.*);
